FILE: rtl/core/stt_pkg.sv
// Package for the sparse triplet transpose block: field widths, request
// codes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package stt_pkg;

    localparam int unsigned DATA_W      = 32;   // element value width
    localparam int unsigned IDX_FW      = 3;    // row/column field width
    localparam int unsigned MAX_DIM_DEF = 8;    // default matrix dimension

    // action field codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic load_en;      // write the incoming element into the store
        logic scan_start;   // reset the scan position
        logic scan_step;    // visit the current scan position
        logic flush;        // scan done: release the held result as the last one
    } stt_cmd_t;

    typedef struct packed {
        logic adv;          // pipeline may move this cycle
        logic s1_vld;       // a read is in flight
        logic scan_last;    // scan position is the final entry
    } stt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/stt_if.sv
// Valid/ready channel interfaces for the element requests and result items.
// Depends on stt_pkg.
`default_nettype none

interface stt_in_if;
    import stt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [IDX_FW-1:0]        elem_row;
    logic [IDX_FW-1:0]        elem_col;
    logic signed [DATA_W-1:0] elem_value;

    modport source (output valid, action, elem_row, elem_col, elem_value, input ready);
    modport sink   (input valid, action, elem_row, elem_col, elem_value, output ready);
endinterface

interface stt_out_if;
    import stt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_FW-1:0]        out_row;
    logic [IDX_FW-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;

    modport source (output valid, out_row, out_col, out_value, out_last, input ready);
    modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stt_ctrl.sv
// Controller for the sparse triplet transpose: accepts requests, sequences
// the transpose scan and the final drain. Depends on stt_pkg.
`default_nettype none

module stt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_action,
    output logic                   in_ready,
    input  wire stt_pkg::stt_stat_t stat,
    output stt_pkg::stt_cmd_t      cmd
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    if (in_action == ACT_FINISH)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.adv && stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.flush = 1'b1;
                // the flush happens on the step where nothing is left in flight
                if (stat.adv && !stat.s1_vld)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

FILE: rtl/core/stt_dp.sv
// Datapath for the sparse triplet transpose: occupancy bits, value RAM,
// scan counter, read stage, one-result hold and output register.
// Depends on stt_pkg, stt_if and stt_ram.
`default_nettype none

module stt_dp #(
    parameter int unsigned MAX_DIM = stt_pkg::MAX_DIM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire stt_pkg::stt_cmd_t                cmd,
    output stt_pkg::stt_stat_t                    stat,
    input  wire logic [stt_pkg::IDX_FW-1:0]       elem_row,
    input  wire logic [stt_pkg::IDX_FW-1:0]       elem_col,
    input  wire logic signed [stt_pkg::DATA_W-1:0] elem_value,
    stt_out_if.source                             result
);
    import stt_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_DIM);
    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CMP_W  = IDX_FW + 1;
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_DIM - 1);
    localparam logic [ADDR_W-1:0] STRIDE   = ADDR_W'(MAX_DIM);
    localparam logic [CMP_W-1:0]  DIM_CMP  = CMP_W'(MAX_DIM);

    // a set bit marks a nonzero entry; a clear one reads as zero
    logic [DEPTH-1:0]   occ_reg;

    logic [IDX_W-1:0]   scan_row_reg, scan_col_reg;
    logic [ADDR_W-1:0]  scan_addr;

    logic               ld_in_range;
    logic               ld_nonzero;
    logic [ADDR_W-1:0]  ld_addr;

    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_row_reg, s1_col_reg;

    logic               h_vld_reg;
    logic [IDX_W-1:0]   h_row_reg, h_col_reg;
    logic [DATA_W-1:0]  h_value_reg;

    logic               o_vld_reg;
    logic [IDX_FW-1:0]  o_row_reg, o_col_reg;
    logic [DATA_W-1:0]  o_value_reg;
    logic               o_last_reg;

    logic               adv;
    logic               hit;
    logic               rd_en;
    logic [DATA_W-1:0]  rd_data;
    logic               push;
    logic               push_last;

    assign ld_in_range = ({1'b0, elem_row} < DIM_CMP) && ({1'b0, elem_col} < DIM_CMP);
    assign ld_nonzero  = (elem_value != '0);
    assign ld_addr     = ADDR_W'(elem_row[IDX_W-1:0]) * STRIDE + ADDR_W'(elem_col[IDX_W-1:0]);
    assign scan_addr   = ADDR_W'(scan_row_reg) * STRIDE + ADDR_W'(scan_col_reg);

    assign adv   = !o_vld_reg || result.ready;
    assign hit   = occ_reg[scan_addr];
    assign rd_en = cmd.scan_step && adv && hit;

    // hold one result back so the final one can carry the last flag
    assign push      = adv && s1_vld_reg && h_vld_reg;
    assign push_last = adv && !s1_vld_reg && cmd.flush && h_vld_reg;

    stt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load_en && ld_in_range && ld_nonzero),
        .wr_addr (ld_addr),
        .wr_data (elem_value),
        .rd_en   (rd_en),
        .rd_addr (scan_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            s1_vld_reg   <= 1'b0;
            h_vld_reg    <= 1'b0;
            o_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_en && ld_in_range)
            begin
                occ_reg[ld_addr] <= ld_nonzero;
            end
            else if (cmd.scan_step && adv)
            begin
                occ_reg[scan_addr] <= 1'b0;   // store left clear behind the scan
            end

            if (cmd.scan_start)
            begin
                scan_row_reg <= '0;
                scan_col_reg <= '0;
            end
            else if (cmd.scan_step && adv)
            begin
                if (scan_row_reg == IDX_LAST)
                begin
                    scan_row_reg <= '0;
                    scan_col_reg <= scan_col_reg + 1'b1;
                end
                else
                begin
                    scan_row_reg <= scan_row_reg + 1'b1;
                end
            end

            if (adv)
            begin
                s1_vld_reg <= cmd.scan_step && hit;
                if (s1_vld_reg)
                begin
                    h_vld_reg <= 1'b1;
                end
                else if (push_last)
                begin
                    h_vld_reg <= 1'b0;
                end
                o_vld_reg <= push || push_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_row_reg <= scan_row_reg;
            s1_col_reg <= scan_col_reg;
            if (s1_vld_reg)
            begin
                // row and column swap here
                h_row_reg   <= s1_col_reg;
                h_col_reg   <= s1_row_reg;
                h_value_reg <= rd_data;
            end
            if (push || push_last)
            begin
                o_row_reg   <= IDX_FW'(h_row_reg);
                o_col_reg   <= IDX_FW'(h_col_reg);
                o_value_reg <= h_value_reg;
                o_last_reg  <= push_last;
            end
        end
    end

    assign stat.adv       = adv;
    assign stat.s1_vld    = s1_vld_reg;
    assign stat.scan_last = (scan_row_reg == IDX_LAST) && (scan_col_reg == IDX_LAST);

    assign result.valid     = o_vld_reg;
    assign result.out_row   = o_row_reg;
    assign result.out_col   = o_col_reg;
    assign result.out_value = $signed(o_value_reg);
    assign result.out_last  = o_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sparse_triplet_transpose.sv
// Top level of the sparse triplet transpose block: controller plus datapath.
// Depends on stt_pkg, stt_if, stt_ctrl, stt_dp, stt_ram.
//
//   channel  dir  payload                                  request
//   elem     in   action, elem_row, elem_col, elem_value   load or finish
//   result   out  out_row, out_col, out_value, out_last    one transposed entry
//
// Loads can follow each other every cycle.
// A finish scans all MAX_DIM*MAX_DIM entries, one a cycle, then the last results
// pass through the hold and output registers;
// result stalls freeze the scan.
// elem.ready is low from the finish until the last result sits in the output register.
// After reset the store reads as all zeros; ready rises in the cycle after reset is released.
`default_nettype none

module sparse_triplet_transpose #(
    parameter int unsigned MAX_DIM = stt_pkg::MAX_DIM_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stt_in_if.sink     elem,
    stt_out_if.source  result
);
    import stt_pkg::*;

    stt_cmd_t  cmd;
    stt_stat_t stat;

    stt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (elem.valid),
        .in_action (elem.action),
        .in_ready  (elem.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    stt_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .elem_row   (elem.elem_row),
        .elem_col   (elem.elem_col),
        .elem_value (elem.elem_value),
        .result     (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/stt_chk.sv
// Port-level checker for the sparse triplet transpose, bound to the top level.
// Depends on stt_pkg.
`default_nettype none

module stt_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic                             in_action,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [stt_pkg::IDX_FW-1:0]       out_row,
    input wire logic [stt_pkg::IDX_FW-1:0]       out_col,
    input wire logic signed [stt_pkg::DATA_W-1:0] out_value,
    input wire logic                             out_last
);
    import stt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(out_value) && $stable(out_last))
        else $error("stalled result changed");

    // a finish request blocks further requests while the scan runs
    a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == ACT_FINISH |=> !in_ready)
        else $error("request accepted during scan");

    // loads never interrupt request acceptance
    a_load_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == ACT_LOAD |=> in_ready)
        else $error("ready dropped after load");

    // a result that is not the last belongs to a scan still in progress
    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("non-final result outside a scan");

    // emitted values are never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_value != '0)
        else $error("zero value emitted");

endmodule

bind sparse_triplet_transpose stt_chk u_stt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (elem.valid),
    .in_ready  (elem.ready),
    .in_action (elem.action),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_row   (result.out_row),
    .out_col   (result.out_col),
    .out_value (result.out_value),
    .out_last  (result.out_last)
);

`default_nettype wire

FILE: test/testbench.sv
// Testbench for sparse_triplet_transpose: it drives load and finish requests, predicts the
// transposed entries and checks each result item in the order it leaves the block.
// Depends on stt_pkg, stt_if and the RTL of the block.
`default_nettype none

module testbench;
    import stt_pkg::*;

    localparam int unsigned DIM        = MAX_DIM_DEF;
    localparam int          IDLE_LIMIT = 2000;   // cycles with no transfer on either channel
    localparam int          LONG_HOLD  = 300;    // receiver hold-off during the full-store scan
    localparam int          RAND_ITEMS = 320;
    localparam int          DRAIN_WAIT = 100;    // an empty scan still runs through all entries

    typedef struct packed {
        logic              action;
        logic [IDX_FW-1:0] row;
        logic [IDX_FW-1:0] col;
        logic [DATA_W-1:0] value;
    } elem_req_t;

    typedef struct packed {
        logic [IDX_FW-1:0] row;
        logic [IDX_FW-1:0] col;
        logic [DATA_W-1:0] value;
        logic              last;
    } trans_entry_t;

    class transpose_scoreboard;
        logic [DATA_W-1:0] store [DIM][DIM];
        trans_entry_t      expected_q[$];
        int                failures;
        int                checked;
        int                requests;
        int                finishes;

        function new();
            failures = 0;
            checked  = 0;
            requests = 0;
            finishes = 0;
            clear_store();
        endfunction

        function void clear_store();
            foreach (store[r, c])
                store[r][c] = '0;
        endfunction

        // Note an accepted request; a finish queues the whole transpose scan.
        function void note_request(elem_req_t req);
            trans_entry_t ent;
            int           first;
            requests++;
            if (req.action == ACT_LOAD)
            begin
                if (req.row < DIM && req.col < DIM)
                    store[req.row][req.col] = req.value;
            end
            else
            begin
                finishes++;
                first = expected_q.size();
                for (int oc = 0; oc < DIM; oc++)
                begin
                    for (int orow = 0; orow < DIM; orow++)
                    begin
                        if (store[orow][oc] != '0)
                        begin
                            ent.row   = IDX_FW'(oc);
                            ent.col   = IDX_FW'(orow);
                            ent.value = store[orow][oc];
                            ent.last  = 1'b0;
                            expected_q.insert(expected_q.size(), ent);
                        end
                    end
                end
                if (expected_q.size() > first)
                    expected_q[expected_q.size() - 1].last = 1'b1;
                clear_store();
            end
        endfunction

        function void report(string what, trans_entry_t exp_e, trans_entry_t got);
            failures++;
            if (failures <= 10)
                $display({"%0t: %s: expected row %0d col %0d value %h last %b,",
                          " got row %0d col %0d value %h last %b"},
                         $time, what, exp_e.row, exp_e.col, exp_e.value, exp_e.last,
                         got.row, got.col, got.value, got.last);
        endfunction

        function void check_result(trans_entry_t got);
            trans_entry_t exp_e;
            checked++;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            exp_e = expected_q.pop_front();
            if (got.row !== exp_e.row || got.col !== exp_e.col ||
                got.value !== exp_e.value || got.last !== exp_e.last)
                report("result mismatch", exp_e, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_armed;
    int   burst_left;
    int   idle_cycles;

    transpose_scoreboard sb = new();

    stt_in_if  elem_ch ();
    stt_out_if res_ch ();

    sparse_triplet_transpose dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_ch),
        .result (res_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input elem_req_t req);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        elem_ch.valid      <= 1'b1;
        elem_ch.action     <= req.action;
        elem_ch.elem_row   <= req.row;
        elem_ch.elem_col   <= req.col;
        elem_ch.elem_value <= req.value;
        do
            @(posedge clk);
        while (!elem_ch.ready);
        sb.note_request(req);
        @(negedge clk);
    endtask

    task automatic send_load(input int r, input int c, input logic [DATA_W-1:0] v);
        elem_req_t req;
        req.action = ACT_LOAD;
        req.row    = IDX_FW'(r);
        req.col    = IDX_FW'(c);
        req.value  = v;
        send_request(req);
    endtask

    task automatic send_finish(input int r, input int c, input logic [DATA_W-1:0] v);
        elem_req_t req;
        req.action = ACT_FINISH;
        req.row    = IDX_FW'(r);
        req.col    = IDX_FW'(c);
        req.value  = v;
        send_request(req);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin : elem_source
        int sent;
        int seq_no;
        int loads;
        bit full_fill;
        rst_n              <= 1'b0;
        elem_ch.valid      <= 1'b0;
        elem_ch.action     <= ACT_LOAD;
        elem_ch.elem_row   <= '0;
        elem_ch.elem_col   <= '0;
        elem_ch.elem_value <= '0;
        hold_armed = 1'b0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners with extreme values, overwrite, erase, erase of an empty entry
        send_load(0, 0, 32'h8000_0000);
        send_load(7, 7, 32'h7fff_ffff);
        send_load(0, 7, 32'hffff_ffff);
        send_load(7, 0, 32'h0000_0001);
        send_load(3, 4, 32'h0000_0005);
        send_load(3, 4, 32'h1234_5678);
        send_load(2, 2, 32'h0000_0009);
        send_load(2, 2, 32'h0000_0000);
        send_load(5, 1, 32'h0000_0000);
        send_finish(0, 0, 32'h0000_0000);
        // finish on a cleared store, with all ignored fields set
        send_finish(7, 7, 32'hffff_ffff);
        send_load(1, 6, 32'haaaa_aaaa);
        send_load(6, 1, 32'h5555_5555);
        send_finish(3, 5, 32'h0000_005a);
        send_load(4, 4, 32'h0000_0000);
        send_finish(0, 0, 32'h0000_0000);

        sent   = 0;
        seq_no = 0;
        while (sent < RAND_ITEMS)
        begin
            full_fill = (seq_no == 4);
            if (full_fill)
            begin
                // every position nonzero: the most results from one scan, with the long hold-off
                for (int r = 0; r < DIM; r++)
                    for (int c = 0; c < DIM; c++)
                        send_load(r, c, ($urandom | 32'h1) ^ {r[2:0], c[2:0], 26'h0});
                sent += DIM * DIM;
                hold_armed = 1'b1;
            end
            else
            begin
                loads = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                for (int i = 0; i < loads; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_load($urandom_range(2, 3), $urandom_range(5, 6), pick_value());
                    else
                        send_load($urandom_range(0, 7), $urandom_range(0, 7), pick_value());
                end
                sent += loads;
            end
            if ($urandom_range(0, 1) == 0)
                send_finish(0, 0, 32'h0);
            else
                send_finish($urandom_range(0, 7), $urandom_range(0, 7), $urandom);
            sent++;
            seq_no++;
        end
        elem_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d requests in %0d finish scans, %0d transposed entries checked,",
                 sb.requests, sb.finishes, sb.checked);
        $display("including a full store and a long result stall; %0d failures.",
                 sb.failures + sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: changing stall pattern, plus one long hold-off once armed
    initial
    begin : result_sink
        int mode;
        int left;
        int phase;
        res_ch.ready <= 1'b0;
        mode  = 0;
        left  = 0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_armed && res_ch.valid)
            begin
                hold_armed = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 64);
                end
                left--;
                phase++;
                case (mode)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (phase % 4 == 0);
                    default: res_ch.ready <= (phase % 7 < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        trans_entry_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.row   = res_ch.out_row;
            got.col   = res_ch.out_col;
            got.value = res_ch.out_value;
            got.last  = res_ch.out_last;
            sb.check_result(got);
        end
    end

    // Watchdog on cycles with no transfer
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((elem_ch.valid && elem_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/stt_pkg.sv
rtl/core/stt_if.sv
rtl/core/stt_ram.sv
rtl/core/stt_ctrl.sv
rtl/core/stt_dp.sv
rtl/core/sparse_triplet_transpose.sv
rtl/core/stt_chk.sv
test/testbench.sv
